FILE: hdl/ult_pkg.sv
// shared types and constants for the unsorted list table
package ult_pkg;

	localparam int ULT_CAPACITY = 16;
	localparam int WORD_W = 32;
	localparam int LEN_W = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_CLEAR  = 2'd3
	} ult_op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} ult_status_t;

	typedef struct packed {
		logic append;
		logic remove;
	} ult_store_cmd_t;

endpackage

FILE: hdl/ult_store.sv
// entry row of the list: parallel match, first-match shift on delete, tail append
module ult_store import ult_pkg::*; #(
	parameter int CAPACITY = ULT_CAPACITY,
	parameter int CNT_W = $clog2(ULT_CAPACITY + 1)
) (
	input  logic                 clk,
	input  ult_store_cmd_t       cmd,
	input  logic [CNT_W-1:0]     count,
	input  logic [WORD_W-1:0]    value,
	output logic                 hit
);

	logic [WORD_W-1:0] entry_q [CAPACITY];
	logic [WORD_W-1:0] shift_src [CAPACITY];
	logic [CAPACITY-1:0] match;
	logic [CAPACITY-1:0] shift_mask;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = (CNT_W'(i) < count) && (entry_q[i] == value);
		end
	end

	// every position at or above the first match moves down by one
	assign shift_mask = match | (~match + CAPACITY'(1));
	assign hit = |match;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g < CAPACITY - 1) begin : g_mid
			assign shift_src[g] = entry_q[g + 1];
		end else begin : g_last
			assign shift_src[g] = entry_q[g];
		end

		always_ff @(posedge clk) begin
			if (cmd.append && (count == CNT_W'(g))) begin
				entry_q[g] <= value;
			end else if (cmd.remove && shift_mask[g]) begin
				entry_q[g] <= shift_src[g];
			end
		end
	end

endmodule

FILE: hdl/unsorted_list_table_unit.sv
// Unsorted list table: a list of up to CAPACITY signed 32-bit words in insertion
// order, taking insert, delete-first-match, search and clear beats. Each beat is
// registered on entry into the input register, then compared against every held
// entry at once, the entry row is updated (tail write or one-place shift from the
// first match) and the result is registered into the output register, so a beat
// is accepted every cycle while the receiver takes results. A result held by the
// receiver stalls the input once the input register is also occupied. The
// parallel compare and first-match shift work over the whole entry row at once.
// Reset clears the entry count and the valid flags, not the entries; no clearing
// pass is needed and the block is ready right after reset.
module unsorted_list_table_unit import ult_pkg::*; #(
	parameter int CAPACITY = ULT_CAPACITY
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               operation,
	input  logic signed [WORD_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic [LEN_W-1:0]         length,
	output logic                     full_res
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                s1_valid_q;
	ult_op_t             op_s1;
	logic [WORD_W-1:0]   value_s1;
	logic [CNT_W-1:0]    count_q;
	logic                out_valid_q;
	ult_status_t         status_q;
	logic [LEN_W-1:0]    length_q;
	logic                full_q;

	logic                advance;
	logic                in_accept;
	logic                hit;
	logic                is_full;
	ult_store_cmd_t      store_cmd;
	ult_status_t         status_d;
	logic [CNT_W-1:0]    count_d;

	assign advance   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready  = !s1_valid_q || advance;
	assign in_accept = in_valid && in_ready;
	assign is_full   = (count_q == CNT_W'(CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1    <= ult_op_t'(operation);
			value_s1 <= value;
		end
	end

	always_comb begin
		store_cmd = '0;
		status_d  = ST_DONE;
		count_d   = count_q;
		unique case (op_s1)
			OP_INSERT: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					store_cmd.append = advance;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				store_cmd.remove = advance;
				if (hit) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					status_d = ST_MISS;
				end
			end
			OP_SEARCH: begin
				if (!hit) begin
					status_d = ST_MISS;
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	ult_store #(
		.CAPACITY (CAPACITY),
		.CNT_W    (CNT_W)
	) u_store (
		.clk   (clk),
		.cmd   (store_cmd),
		.count (count_q),
		.value (value_s1),
		.hit   (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			length_q <= LEN_W'(count_d);
			full_q   <= (count_d == CNT_W'(CAPACITY));
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign length    = length_q;
	assign full_res  = full_q;

`ifndef SYNTHESIS
	// count stays within capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// a pending result always matches the live count
	a_len_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (length_q == LEN_W'(count_q)) &&
			(full_q == (count_q == CNT_W'(CAPACITY))))
		else $error("result length out of step with count");

	// a full rejection only when the list really is full
	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_FULL)) |-> (count_q == CNT_W'(CAPACITY)))
		else $error("full status with room left");

	// a held beat is never overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && s1_valid_q) |-> advance)
		else $error("input stage overwritten");

	// count moves by at most one except on clear
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (op_s1 != OP_CLEAR)) |=>
			((count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)) ||
			(count_q == $past(count_q) - CNT_W'(1))))
		else $error("count jumped");
`endif

endmodule
